// ----- design/two_level_branch_predictor_top_defines.svh -----
// ----------------------------------------------------------------------------
// Two-level branch predictor assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define TWO_LEVEL_BRANCH_PREDICTOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TLBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define TLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TLBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/tlbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-level branch predictor package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package tlbp_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_HISTORY = 8;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_MID  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_BITS      = 3'd0,
        CFG_TAG_LENGTH      = 3'd1,
        CFG_HISTORY_LENGTH  = 3'd2,
        CFG_INITIAL_COUNTER = 3'd3,
        CFG_GLOBAL_HISTORY  = 3'd4,
        CFG_GLOBAL_TABLE    = 3'd5,
        CFG_SHARE_MODE      = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0] index_bits;
        logic [4:0] tag_length;
        logic [3:0] history_length;
        logic [1:0] initial_counter;
        logic       global_history;
        logic       global_table;
        logic [1:0] share_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        index_bits:      3'd5,
        tag_length:      5'd20,
        history_length:  4'd8,
        initial_counter: 2'd1,
        global_history:  1'b0,
        global_table:    1'b0,
        share_mode:      SHARE_NONE
    };

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target;
        logic              taken;
    } t_req;

    typedef struct packed {
        logic              predicted_taken;
        logic [ADDR_W-1:0] predicted_target;
        logic              flush;
        logic [31:0]       branch_count;
        logic [31:0]       flush_count;
    } t_rsp;

endpackage

// ----- design/two_level_branch_predictor_top.sv -----
// A request is taken only in idle; the accept cycle reads the entry and
// counter-row RAMs, the execute state does the read-modify-write of both
// on an update and registers the result, holding while an old one waits.
// Reset: synchronous; clears control, counts, shared history and the RAM
// valid bits (no clearing pass); config writes re-mark every counter row.
// ----------------------------------------------------------------------------
// Two-level branch predictor top
// Direct-mapped BTB with local/global history and 2-bit counter rows.
// ----------------------------------------------------------------------------
`include "two_level_branch_predictor_top_defines.svh"

module two_level_branch_predictor_top #(
    parameter int MAX_ENTRIES = tlbp_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_HISTORY = tlbp_pkg::DEF_MAX_HISTORY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tlbp_pkg::t_req                     i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tlbp_pkg::t_rsp                     o_out_rsp,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tlbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tlbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import tlbp_pkg::*;

    localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IB_MAX  = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int MH      = MAX_HISTORY;
    localparam int ROW_LEN = 1 << MH;
    localparam int ROW_W   = 2 * ROW_LEN;
    localparam int EW      = MH + ADDR_W + TAG_W;

    // configuration
    t_cfg r_cfg, n_cfg;
    logic cfg_refill;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg      = r_cfg;
        cfg_refill = 1'b0;
        if (i_cfg_valid) begin
            cfg_refill = 1'b1;
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INDEX_BITS:      n_cfg.index_bits      = i_cfg_data[2:0];
                CFG_TAG_LENGTH:      n_cfg.tag_length      = i_cfg_data[4:0];
                CFG_HISTORY_LENGTH:  n_cfg.history_length  = i_cfg_data[3:0];
                CFG_INITIAL_COUNTER: n_cfg.initial_counter = i_cfg_data[1:0];
                CFG_GLOBAL_HISTORY:  n_cfg.global_history  = i_cfg_data[0];
                CFG_GLOBAL_TABLE:    n_cfg.global_table    = i_cfg_data[0];
                CFG_SHARE_MODE:      n_cfg.share_mode      = i_cfg_data[1:0];
                default:             cfg_refill            = 1'b0;
            endcase
        end
    end

    // effective sizes
    logic [3:0]    ib;
    logic [4:0]    tl_lim, tl;
    logic [4:0]    hl_raw, hl;
    logic [MH-1:0] hmask;

    always_comb begin
        ib     = ({1'b0, r_cfg.index_bits} > 4'(IB_MAX)) ? 4'(IB_MAX)
                                                         : {1'b0, r_cfg.index_bits};
        tl_lim = 5'd30 - {1'b0, ib};
        tl     = (r_cfg.tag_length > tl_lim) ? tl_lim : r_cfg.tag_length;
        hl_raw = {1'b0, r_cfg.history_length};
        if (hl_raw == 5'd0) begin
            hl = 5'd1;
        end else if (hl_raw > 5'(MH)) begin
            hl = 5'(MH);
        end else begin
            hl = hl_raw;
        end
        hmask = ~({MH{1'b1}} << hl);
    end

    // request decode in the accept cycle
    logic [AW-1:0]     in_entry, in_row;
    logic [ADDR_W-1:0] pc_sh;
    logic [TAG_W-1:0]  in_tag;

    always_comb begin
        in_entry = i_in_req.pc[AW+1:2] & ~({AW{1'b1}} << ib);
        in_row   = r_cfg.global_table ? '0 : in_entry;
        pc_sh    = i_in_req.pc >> (6'd2 + {2'b00, ib});
        in_tag   = pc_sh[TAG_W-1:0] & ~({TAG_W{1'b1}} << tl);
    end

    // control
    t_state r_state, n_state;
    logic   in_accept, done_exec;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_EXEC;
            S_EXEC: if (done_exec) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        done_exec  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_EXEC: done_exec  = !o_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;

    // request registers
    t_req             r_req;
    logic [AW-1:0]    r_entry, r_row;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req   <= i_in_req;
            r_entry <= in_entry;
            r_row   <= in_row;
            r_tag   <= in_tag;
        end
    end

    // memories
    logic [EW-1:0]    ent_rd, ent_wr;
    logic [ROW_W-1:0] row_rd, row_wr, row_fill;
    logic             wr_en;

    assign row_fill = {ROW_LEN{r_cfg.initial_counter}};
    assign wr_en    = done_exec && (r_req.operation == OP_UPDATE);

    tlbp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (1'b0),
        .i_fill    ({EW{1'b0}}),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_entry),
        .o_rd_data (ent_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_entry),
        .i_wr_data (ent_wr)
    );

    tlbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_counter_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_refill),
        .i_fill    (row_fill),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_row),
        .o_rd_data (row_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (row_wr)
    );

    // execute: prediction, flush and write-back
    logic [MH-1:0]     r_shared, n_shared;
    logic [31:0]       r_branches, r_flushes;
    logic [TAG_W-1:0]  ent_tag;
    logic [ADDR_W-1:0] ent_target, pc_next;
    logic [MH-1:0]     ent_hist, old_local, hist, idx, new_local;
    logic              hit;
    logic [ROW_W-1:0]  row_eff;
    logic [1:0]        ctr, ctr_new;
    logic              pred, flush;
    t_rsp              n_rsp;

    always_comb begin
        {ent_hist, ent_target, ent_tag} = ent_rd;
        hit       = (ent_tag == r_tag);
        pc_next   = r_req.pc + 32'd4;
        old_local = hit ? ent_hist : '0;
        hist      = hit ? (r_cfg.global_history ? r_shared : ent_hist) : '0;
        idx       = hist & hmask;
        if (r_cfg.global_table) begin
            unique case (r_cfg.share_mode)
                SHARE_NONE: ;
                SHARE_LOW:  idx = idx ^ (r_req.pc[2 +: MH] & hmask);
                // mode three behaves as the mid share
                default:    idx = idx ^ (r_req.pc[16 +: MH] & hmask);
            endcase
        end
        // a miss in per-entry mode starts from a refilled row
        row_eff = (!hit && !r_cfg.global_table) ? row_fill : row_rd;
        ctr     = row_eff[{idx, 1'b0} +: 2];
        pred    = hit && ctr[1];

        flush = 1'b0;
        if (pred != r_req.taken) begin
            flush = pred ? (pc_next != ent_target) : (r_req.target != pc_next);
        end else if (r_req.taken) begin
            flush = (r_req.target != ent_target);
        end

        ctr_new = ctr;
        if (r_req.taken) begin
            if (ctr != 2'd3) ctr_new = ctr + 2'd1;
        end else begin
            if (ctr != 2'd0) ctr_new = ctr - 2'd1;
        end
        row_wr = row_eff;
        row_wr[{idx, 1'b0} +: 2] = ctr_new;

        new_local = old_local;
        n_shared  = r_shared;
        if (r_cfg.global_history) begin
            n_shared = ((r_shared << 1) | MH'(r_req.taken)) & hmask;
        end else begin
            new_local = ((old_local << 1) | MH'(r_req.taken)) & hmask;
        end
        ent_wr = {new_local, r_req.target, r_tag};

        n_rsp.predicted_taken  = pred;
        n_rsp.predicted_target = pred ? ent_target : pc_next;
        n_rsp.flush            = (r_req.operation == OP_UPDATE) && flush;
        n_rsp.branch_count     = r_branches + {31'd0, r_req.operation == OP_UPDATE};
        n_rsp.flush_count      = r_flushes + {31'd0, n_rsp.flush};
    end

    // registers
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (done_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_shared    <= '0;
            r_branches  <= '0;
            r_flushes   <= '0;
        end else begin
            r_cfg       <= n_cfg;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_shared <= n_shared;
            end
            if (done_exec) begin
                r_branches <= n_rsp.branch_count;
                r_flushes  <= n_rsp.flush_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_exec) begin
            o_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;

    // assertions
    `TLBP_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, in_accept, r_state == S_EXEC)
    `TLBP_ASSERT_IMPLY(a_flush_update, i_clk, i_rst_n, done_exec && n_rsp.flush, r_req.operation == OP_UPDATE)
    `TLBP_ASSERT_NEXT(a_predict_count, i_clk, i_rst_n, done_exec && (r_req.operation == OP_PREDICT), $stable(r_branches))

endmodule

// ----- design/tlbp_ram.sv -----
// ----------------------------------------------------------------------------
// Predictor RAM
// Single-port-write, registered-read memory with per-row valid bits; an
// invalid row reads as the fill value.
// ----------------------------------------------------------------------------
module tlbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [WIDTH-1:0] i_fill,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : i_fill;

endmodule

// ----- test/two_level_branch_predictor_checker.sv -----
// ----------------------------------------------------------------------------
// Two-level branch predictor checker
// Watches the request, result and register-write channels. Keeps its own
// copy of the target buffer, histories, counter table and counts, predicts
// each result and compares it field by field. Failures are counted.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_checker #(
    parameter int MAX_ENTRIES = tlbp_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_HISTORY = tlbp_pkg::DEF_MAX_HISTORY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  tlbp_pkg::t_req                  i_in_req,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  tlbp_pkg::t_rsp                  i_out_rsp,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tlbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_result_count,
    output int                              o_taken_count,
    output int                              o_flush_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlbp_pkg::*;

    localparam int ROW_LEN = 1 << MAX_HISTORY;
    localparam int CTR_DEPTH = MAX_ENTRIES * ROW_LEN;

    t_cfg                   regs;
    logic [TAG_W-1:0]       tag_mem    [MAX_ENTRIES];
    logic [ADDR_W-1:0]      tgt_mem    [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0] local_hist [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0] shared_hist;
    logic [1:0]             ctr_mem    [CTR_DEPTH];
    logic [31:0]            branches;
    logic [31:0]            flushes;

    t_rsp rsp_queue [$];
    int   fails = 0;
    int   results = 0;
    int   takens = 0;
    int   flush_total = 0;

    assign o_fail_count   = fails;
    assign o_result_count = results;
    assign o_taken_count  = takens;
    assign o_flush_count  = flush_total;

    function automatic logic [31:0] low_ones(input int n);
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    endfunction

    // index width saturates at what the buffer can hold
    function automatic int active_index_bits();
        int ib;
        ib = int'(regs.index_bits);
        while (ib > 0 && (1 << ib) > MAX_ENTRIES) ib--;
        return ib;
    endfunction

    function automatic int active_hist_len();
        int h;
        h = int'(regs.history_length);
        if (h < 1) h = 1;
        if (h > MAX_HISTORY) h = MAX_HISTORY;
        return h;
    endfunction

    function automatic void refill_counters(input int first, input int count);
        for (int k = first; k < first + count; k++) begin
            ctr_mem[k] = regs.initial_counter;
        end
    endfunction

    function automatic void reset_model();
        regs = CFG_RESET;
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            tag_mem[e]    = '0;
            tgt_mem[e]    = '0;
            local_hist[e] = '0;
        end
        shared_hist = '0;
        branches    = '0;
        flushes     = '0;
        refill_counters(0, CTR_DEPTH);
    endfunction

    // unlisted indexes leave everything alone, listed ones refill the table
    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INDEX_BITS:      regs.index_bits      = data[2:0];
            CFG_TAG_LENGTH:      regs.tag_length      = data[4:0];
            CFG_HISTORY_LENGTH:  regs.history_length  = data[3:0];
            CFG_INITIAL_COUNTER: regs.initial_counter = data[1:0];
            CFG_GLOBAL_HISTORY:  regs.global_history  = data[0];
            CFG_GLOBAL_TABLE:    regs.global_table    = data[0];
            CFG_SHARE_MODE:      regs.share_mode      = data[1:0];
            default:             return;
        endcase
        refill_counters(0, CTR_DEPTH);
    endfunction

    function automatic t_rsp predict_branch(input t_req r);
        int          ib;
        int          tl;
        int          hl;
        logic [31:0] entry;
        logic [31:0] tag;
        logic [31:0] hist;
        logic [31:0] idx;
        logic [31:0] slot;
        logic [31:0] stored;
        logic [31:0] link;
        logic        hit;
        logic        pred;
        logic        flush;
        t_rsp        rsp;

        ib = active_index_bits();
        tl = int'(regs.tag_length);
        if (tl > 30 - ib) tl = 30 - ib;
        hl = active_hist_len();

        entry = (r.pc >> 2) & low_ones(ib);
        tag   = (r.pc >> (2 + ib)) & low_ones(tl);
        hit   = (tag_mem[entry] == tag[TAG_W-1:0]);

        // a miss reads the counter as if the history were zero
        hist = '0;
        if (hit) begin
            hist = regs.global_history ? 32'(shared_hist) : 32'(local_hist[entry]);
        end
        idx = hist & low_ones(hl);
        if (regs.global_table) begin
            if (regs.share_mode == SHARE_LOW) begin
                idx = idx ^ ((r.pc >> 2) & low_ones(hl));
            end else if (regs.share_mode >= SHARE_MID) begin
                idx = idx ^ ((r.pc >> 16) & low_ones(hl));
            end
            slot = idx;
        end else begin
            slot = entry * 32'(ROW_LEN) + idx;
        end

        pred   = hit && (ctr_mem[slot] > 2'd1);
        stored = tgt_mem[entry];
        link   = r.pc + 32'd4;
        flush  = 1'b0;

        if (r.operation == OP_UPDATE) begin
            branches = branches + 32'd1;
            if (pred != r.taken) begin
                flush = pred ? (link != stored) : (r.target != link);
            end else if (r.taken) begin
                flush = (r.target != stored);
            end
            if (flush) flushes = flushes + 32'd1;

            if (!hit) begin
                tag_mem[entry]    = tag[TAG_W-1:0];
                local_hist[entry] = '0;
                if (!regs.global_table) refill_counters(int'(entry) * ROW_LEN, ROW_LEN);
            end
            if (regs.global_history) begin
                shared_hist = MAX_HISTORY'(((32'(shared_hist) << 1) | 32'(r.taken))
                                           & low_ones(hl));
            end else begin
                local_hist[entry] = MAX_HISTORY'(((32'(local_hist[entry]) << 1)
                                                  | 32'(r.taken)) & low_ones(hl));
            end
            tgt_mem[entry] = r.target;

            if (r.taken) begin
                if (ctr_mem[slot] != 2'd3) ctr_mem[slot] = ctr_mem[slot] + 2'd1;
            end else begin
                if (ctr_mem[slot] != 2'd0) ctr_mem[slot] = ctr_mem[slot] - 2'd1;
            end
        end

        rsp.predicted_taken  = pred;
        rsp.predicted_target = pred ? stored : link;
        rsp.flush            = flush;
        rsp.branch_count     = branches;
        rsp.flush_count      = flushes;
        return rsp;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            reset_model();
            rsp_queue.delete();
        end else begin
            // results first, so a stray result never pairs with a fresh request
            if (i_out_valid && i_out_ready) begin
                results++;
                if (rsp_queue.size() == 0) begin
                    $error("result with no request outstanding: %h", i_out_rsp);
                    fails++;
                end else begin
                    want = rsp_queue.pop_front();
                    compare_field("predicted_taken", 32'(want.predicted_taken),
                                  32'(i_out_rsp.predicted_taken));
                    compare_field("predicted_target", want.predicted_target,
                                  i_out_rsp.predicted_target);
                    compare_field("flush", 32'(want.flush), 32'(i_out_rsp.flush));
                    compare_field("branch_count", want.branch_count,
                                  i_out_rsp.branch_count);
                    compare_field("flush_count", want.flush_count, i_out_rsp.flush_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                want = predict_branch(i_in_req);
                rsp_queue.push_back(want);
                if (want.predicted_taken) takens++;
                if (want.flush) flush_total++;
            end
        end
        o_pending <= rsp_queue.size();
    end

endmodule

// ----- test/two_level_branch_predictor_top_tb.sv -----
// ----------------------------------------------------------------------------
// Two-level branch predictor testbench
// Resets the block, runs a short directed sequence, then random phases under
// a range of register settings (saturating values included). Branch requests
// come mostly from a small pool per phase so entries hit and counters train.
// Both channels idle at random; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 3'd7;
    localparam logic [1:0]           SHARE_ALIAS  = 2'd3;   // behaves as mid share

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int POOL_MAX        = 10;
    localparam int FIXED_PLANS     = 6;

    localparam logic [31:0] LOOP_PC  = 32'h0000_1000;
    localparam logic [31:0] LOOP_TGT = 32'h0000_2000;

    // index_bits, tag_length, history_length, initial_counter,
    // global_history, global_table, share_mode
    localparam t_cfg CFG_PLAN [FIXED_PLANS] = '{
        '{3'd0, 5'd0,  4'd1,  2'd0, 1'b0, 1'b0, SHARE_NONE},
        '{3'd7, 5'd31, 4'd15, 2'd3, 1'b1, 1'b1, SHARE_ALIAS},
        '{3'd5, 5'd30, 4'd0,  2'd2, 1'b1, 1'b0, SHARE_LOW},
        '{3'd2, 5'd4,  4'd4,  2'd1, 1'b0, 1'b1, SHARE_LOW},
        '{3'd3, 5'd10, 4'd9,  2'd2, 1'b1, 1'b1, SHARE_MID},
        '{3'd1, 5'd3,  4'd2,  2'd0, 1'b0, 1'b1, SHARE_MID}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_req                  in_req    = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_rsp                  out_rsp;
    logic                  cfg_ready;

    int pending;
    int fail_count;
    int result_count;
    int taken_count;
    int flush_count;
    int sent = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    always #5 clk = ~clk;

    two_level_branch_predictor_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    two_level_branch_predictor_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_req       (in_req),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_rsp      (out_rsp),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_taken_count  (taken_count),
        .o_flush_count  (flush_count)
    );

    function automatic t_req mk_req(input logic op, input logic [31:0] pc,
                                    input logic [31:0] tgt, input logic taken);
        t_req r;
        r.operation = op;
        r.pc        = pc;
        r.target    = tgt;
        r.taken     = taken;
        return r;
    endfunction

    // valid is only dropped ahead of a real gap, never in the step it rises
    task automatic send_request(input t_req r);
        int gap;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 19));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // unused upper data bits carry noise; the block must mask them
    task automatic program_regs(input t_cfg s);
        write_reg(CFG_INDEX_BITS, {2'($urandom_range(0, 3)), s.index_bits});
        write_reg(CFG_TAG_LENGTH, s.tag_length);
        write_reg(CFG_HISTORY_LENGTH, {1'($urandom_range(0, 1)), s.history_length});
        write_reg(CFG_INITIAL_COUNTER, {3'($urandom_range(0, 7)), s.initial_counter});
        write_reg(CFG_GLOBAL_HISTORY, {4'($urandom_range(0, 15)), s.global_history});
        write_reg(CFG_GLOBAL_TABLE, {4'($urandom_range(0, 15)), s.global_table});
        write_reg(CFG_SHARE_MODE, {3'($urandom_range(0, 7)), s.share_mode});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // all-zero tag matches the cleared buffer right after reset
        send_request(mk_req(OP_PREDICT, 32'h0, 32'hFFFF_FFFF, 1'b1));
        send_request(mk_req(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b1));
        send_request(mk_req(OP_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0));
        send_request(mk_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0, 1'b0));
        // taken to pc+4, which wraps to zero: no flush
        send_request(mk_req(OP_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b1));
        repeat (10) send_request(mk_req(OP_UPDATE, LOOP_PC, LOOP_TGT, 1'b1));
        send_request(mk_req(OP_PREDICT, LOOP_PC, 32'h0, 1'b0));
        // taken both ways but to a new target, then a mispredicted fall-through
        send_request(mk_req(OP_UPDATE, LOOP_PC, LOOP_TGT + 32'h1000, 1'b1));
        send_request(mk_req(OP_UPDATE, LOOP_PC, LOOP_TGT, 1'b0));
        send_request(mk_req(OP_UPDATE, LOOP_PC, LOOP_PC + 32'd4, 1'b1));
        send_request(mk_req(OP_PREDICT, LOOP_PC, 32'hFFFF_FFFF, 1'b1));
    endtask

    task automatic run_random(input int count, input bit poke_unlisted);
        logic [31:0] pool_pc   [POOL_MAX];
        logic [31:0] pool_tgt  [POOL_MAX];
        int          pool_bias [POOL_MAX];
        int          n;
        int          k;
        int          roll;
        t_req        r;

        n = int'($urandom_range(1, POOL_MAX));
        for (int j = 0; j < POOL_MAX; j++) begin
            pool_pc[j]   = $urandom();
            pool_tgt[j]  = $urandom();
            pool_bias[j] = ($urandom_range(0, 1) != 0) ? 95 : int'($urandom_range(0, 100));
        end
        for (int i = 0; i < count; i++) begin
            if (poke_unlisted && i == count / 2) begin
                // trained counters must survive a write to an unlisted index
                drain_results();
                write_reg(CFG_UNLISTED, 5'($urandom_range(0, 31)));
                cfg_valid <= 1'b0;
            end else if ($urandom_range(0, 39) == 0) begin
                drain_results();
            end
            roll = int'($urandom_range(0, 99));
            if (roll < 80) begin
                k = int'($urandom_range(0, n - 1));
                case ($urandom_range(0, 19))
                    0:       pool_tgt[k] = $urandom();
                    1:       pool_tgt[k] = pool_pc[k] + 32'd4;
                    default: ;
                endcase
                r.operation = ($urandom_range(0, 3) == 0) ? OP_PREDICT : OP_UPDATE;
                r.pc        = pool_pc[k];
                r.target    = pool_tgt[k];
                r.taken     = (int'($urandom_range(0, 99)) < pool_bias[k]);
            end else begin
                r.operation = ($urandom_range(0, 1) != 0) ? OP_UPDATE : OP_PREDICT;
                r.pc        = $urandom();
                r.target    = $urandom();
                r.taken     = 1'($urandom_range(0, 1));
            end
            send_request(r);
        end
    endtask

    // result side: random stall before each result, some phases without stalls
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_quiet ? 0 : int'($urandom_range(0, 19));
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        t_cfg s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p < FIXED_PLANS) begin
                s = CFG_PLAN[p];
            end else begin
                s.index_bits      = 3'($urandom_range(0, 7));
                s.tag_length      = 5'($urandom_range(0, 31));
                s.history_length  = 4'($urandom_range(0, 15));
                s.initial_counter = 2'($urandom_range(0, 3));
                s.global_history  = 1'($urandom_range(0, 1));
                s.global_table    = 1'($urandom_range(0, 1));
                s.share_mode      = 2'($urandom_range(0, 3));
            end
            program_regs(s);
            tx_quiet = (p % 3 == 1);
            rx_quiet = (p % 4 == 2);
            run_random(ITEMS_PER_PHASE, p == 3);
        end
        drain_results();
        repeat (10) @(posedge clk);
        $display("Sent %0d branch requests and checked %0d results over %0d register settings,",
                 sent, result_count, PHASES + 1);
        $display("seeing %0d taken predictions and %0d flushes.", taken_count, flush_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $error("timeout: requests or results stopped moving");
        $display("Test completed with failures");
        $finish;
    end

endmodule
